// ----- sv/voice_allocator_oldest_steal_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the voice allocator checker
// Clocked, reset-qualified same-cycle and next-cycle property forms.
// ----------------------------------------------------------------------------
`ifndef VOICE_ALLOCATOR_OLDEST_STEAL_CORE_ASSERT_SVH
`define VOICE_ALLOCATOR_OLDEST_STEAL_CORE_ASSERT_SVH

// same-cycle implication
`define VAOS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication
`define VAOS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ----- sv/vaos_pkg.sv -----
// ----------------------------------------------------------------------------
// vaos_pkg
// Shared types and constants for the oldest-steal voice allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vaos_pkg;

	localparam int VOICES_DEF  = 8;
	localparam int NOTE_W      = 7;
	localparam int LIMIT_W     = 4;
	localparam int COUNT_W     = 4;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

	// req_type codes
	localparam logic REQ_OFF = 1'b0;
	localparam logic REQ_ON  = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [NOTE_W-1:0] note;
	} vaos_req_t;

	typedef struct packed {
		logic [NOTE_W-1:0]  voice_note;
		logic               gate_on;
		logic               stolen;
		logic [COUNT_W-1:0] active_count;
		logic               last_result;
	} vaos_res_t;

	// list update command broadcast to every cell
	typedef struct packed {
		logic              ins;   // shift toward the back, new note into cell 0
		logic              del;   // close the gap at the matching cell
		logic [NOTE_W-1:0] note;  // note searched for / inserted
	} vaos_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/vaos_cell.sv -----
// ----------------------------------------------------------------------------
// vaos_cell
// One list slot: holds a note, compares it, shifts to/from its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vaos_cell (
	input  wire logic                      clk,
	input  wire vaos_pkg::vaos_ctrl_t      ctrl,
	input  wire logic                      active,
	input  wire logic [vaos_pkg::NOTE_W-1:0] left_note,
	input  wire logic [vaos_pkg::NOTE_W-1:0] right_note,
	input  wire logic                      seen_in,
	output logic                           seen_out,
	output logic [vaos_pkg::NOTE_W-1:0]    note_q
);
	import vaos_pkg::*;

	logic match;

	assign match    = active && (note_q == ctrl.note);
	assign seen_out = seen_in | match;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			note_q <= left_note;
		end else if (ctrl.del && seen_out) begin
			note_q <= right_note;
		end
	end

endmodule
`default_nettype wire

// ----- sv/vaos_chain.sv -----
// ----------------------------------------------------------------------------
// vaos_chain
// Row of note cells, newest at cell 0; search carry and oldest-note pick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vaos_chain #(
	parameter int VOICES = vaos_pkg::VOICES_DEF,
	parameter int CNT_W  = $clog2(VOICES + 1)
) (
	input  wire logic                        clk,
	input  wire vaos_pkg::vaos_ctrl_t        ctrl,
	input  wire logic [CNT_W-1:0]            occ,        // current fill
	input  wire logic [CNT_W-1:0]            occ_after,  // fill after a steal
	output logic                             found,
	output logic [vaos_pkg::NOTE_W-1:0]      oldest
);
	import vaos_pkg::*;

	logic [NOTE_W-1:0] notes [VOICES];
	logic [VOICES:0]   seen;
	logic [CNT_W-1:0]  last_idx;

	assign seen[0]  = 1'b0;
	assign found    = seen[VOICES];
	assign last_idx = occ - CNT_W'(1);

	for (genvar i = 0; i < VOICES; i++) begin : g_cell
		logic [NOTE_W-1:0] left_n;
		logic [NOTE_W-1:0] right_n;

		if (i == 0) begin : g_first
			assign left_n = ctrl.note;
		end else begin : g_mid
			assign left_n = notes[i-1];
		end
		if (i == VOICES - 1) begin : g_last
			assign right_n = notes[i];
		end else begin : g_inner
			assign right_n = notes[i+1];
		end

		vaos_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.active    (CNT_W'(i) < occ_after),
			.left_note (left_n),
			.right_note(right_n),
			.seen_in   (seen[i]),
			.seen_out  (seen[i+1]),
			.note_q    (notes[i])
		);
	end

	// back of the list as an AND-OR pick over the cells
	always_comb begin
		oldest = '0;
		for (int i = 0; i < VOICES; i++) begin
			if (CNT_W'(i) == last_idx) begin
				oldest = oldest | notes[i];
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/voice_allocator_oldest_steal_core.sv -----
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal_core
// Oldest-note-stealing voice allocator built as a shifting row of note cells.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready take one key event (req_type, note). Events are taken
//    one at a time: after an accept in_ready stays low while the cell row
//    searches and shifts, until the event is evaluated.
//  - out_valid/out_ready give one result item per handshake. A note-on that
//    steals yields two items (stolen note-off, then the note-on); all other
//    events yield one. The last item of an event has last_result set.
//  - The first result is valid in the cycle after the evaluate cycle. The
//    list update and result write happen in that evaluate cycle, which
//    waits until the output register and the second-result slot have room,
//    so a stalled receiver simply holds the next event in evaluate and keeps
//    in_ready low.
//  - cfg_we/cfg_wdata write voice_limit (0 acts as 1, above VOICES acts as
//    VOICES); write only while idle.
//  - Reset (arst_n low): list empty, voice_limit 8, no results pending. The
//    cell contents are not cleared; cells past the fill count are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module voice_allocator_oldest_steal_core #(
	parameter int VOICES = vaos_pkg::VOICES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [vaos_pkg::LIMIT_W-1:0] cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire vaos_pkg::vaos_req_t          in_item,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output vaos_pkg::vaos_res_t               out_item
);
	import vaos_pkg::*;

	localparam int CNT_W = $clog2(VOICES + 1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EVAL = 1'b1;

	logic               state_q;
	logic [LIMIT_W-1:0] voice_limit_q;
	logic [CNT_W-1:0]   occ_q;
	vaos_req_t          req_s1;
	vaos_res_t          out_q;
	logic               out_valid_q;
	vaos_res_t          pend_q;
	logic               pend_valid_q;

	logic [CMP_W-1:0]   lim_c;
	logic [CMP_W-1:0]   lim_raw;
	logic               is_on;
	logic               steal;
	logic               found;
	logic               ins;
	logic               del;
	logic               fire;
	logic [CNT_W-1:0]   occ_after;
	logic [CNT_W-1:0]   occ_final;
	logic [CMP_W-1:0]   occ_after_w;
	logic [CMP_W-1:0]   occ_final_w;
	logic [NOTE_W-1:0]  oldest;
	vaos_ctrl_t         ctrl;
	vaos_res_t          r_steal;
	vaos_res_t          r_main;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// evaluate only when both result slots can take what this event makes
	assign fire = (state_q == ST_EVAL) && !pend_valid_q && (!out_valid_q || out_ready);

	// effective limit, clamped to 1..VOICES
	assign lim_raw = CMP_W'(voice_limit_q);
	always_comb begin
		lim_c = lim_raw;
		if (lim_raw == '0) begin
			lim_c = CMP_W'(1);
		end else if (lim_raw > CMP_W'(VOICES)) begin
			lim_c = CMP_W'(VOICES);
		end
	end

	assign is_on     = (req_s1.req_type == REQ_ON);
	assign steal     = is_on && (CMP_W'(occ_q) >= lim_c) && (occ_q != '0);
	assign occ_after = occ_q - CNT_W'(steal);
	// search runs over the list as it stands after the steal
	assign ins       = is_on && !found && (occ_after < CNT_W'(VOICES));
	assign del       = !is_on && found;
	assign occ_final = occ_after + CNT_W'(ins) - CNT_W'(del);

	assign ctrl.ins  = fire && ins;
	assign ctrl.del  = fire && del;
	assign ctrl.note = req_s1.note;

	vaos_chain #(
		.VOICES(VOICES),
		.CNT_W (CNT_W)
	) u_chain (
		.clk      (clk),
		.ctrl     (ctrl),
		.occ      (occ_q),
		.occ_after(occ_after),
		.found    (found),
		.oldest   (oldest)
	);

	assign occ_after_w = CMP_W'(occ_after);
	assign occ_final_w = CMP_W'(occ_final);

	always_comb begin
		r_steal.voice_note   = oldest;
		r_steal.gate_on      = 1'b0;
		r_steal.stolen       = 1'b1;
		r_steal.active_count = occ_after_w[COUNT_W-1:0];
		r_steal.last_result  = 1'b0;

		r_main.voice_note    = req_s1.note;
		r_main.gate_on       = is_on;
		r_main.stolen        = 1'b0;
		r_main.active_count  = occ_final_w[COUNT_W-1:0];
		r_main.last_result   = 1'b1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			voice_limit_q <= LIMIT_RESET;
			occ_q         <= '0;
			out_valid_q   <= 1'b0;
			pend_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				voice_limit_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				occ_q        <= occ_final;
				out_valid_q  <= 1'b1;
				pend_valid_q <= steal;
			end else if (out_valid_q && out_ready) begin
				if (pend_valid_q) begin
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_item;
		end
		if (fire) begin
			out_q  <= steal ? r_steal : r_main;
			pend_q <= r_main;
		end else if (out_valid_q && out_ready && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

endmodule
`default_nettype wire

// ----- sv/vaos_checker.sv -----
// ----------------------------------------------------------------------------
// vaos_checker
// Port-level checks for the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "voice_allocator_oldest_steal_core_assert.svh"
module vaos_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire vaos_pkg::vaos_res_t out_item
);
	import vaos_pkg::*;

	// a stalled result item holds
	`VAOS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item))

	// a stolen item is always a non-final note-off
	`VAOS_ASSERT_NOW(a_stolen_shape, clk, arst_n, out_valid && out_item.stolen, !out_item.gate_on && !out_item.last_result)

	// the note-on of the same event follows a stolen item directly
	`VAOS_ASSERT_NEXT(a_steal_then_on, clk, arst_n, out_valid && out_ready && out_item.stolen, out_valid && out_item.gate_on && out_item.last_result)

	// one event at a time: no accept in the cycle after an accept
	`VAOS_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind voice_allocator_oldest_steal_core vaos_checker u_vaos_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);
`default_nettype wire

// ----- tb/voice_allocator_oldest_steal_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal_core_test
// Self-checking bench for the oldest-steal voice allocator. A local model of
// the note list predicts every result item from each accepted key event; a
// monitor compares the result stream field by field. Directed events cover
// fill, stealing, duplicates, absent note-offs and limit extremes; random
// phases follow under several voice limits with idle gaps on both sides.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal_core_test;
	import vaos_pkg::*;

	localparam int VOICES      = VOICES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 8;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	vaos_req_t          in_item = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	vaos_res_t          out_item;

	voice_allocator_oldest_steal_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// 50 MHz
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Note list model: entry 0 newest, entry sounding_cnt-1 oldest
	// ------------------------------------------------------------------
	logic [NOTE_W-1:0]  sounding[VOICES];
	logic [COUNT_W-1:0] sounding_cnt = '0;
	logic [LIMIT_W-1:0] voice_limit = LIMIT_RESET;

	vaos_res_t pending_results[$];
	int        fail_count = 0;
	int        cycle_count = 0;
	bit        tx_throttle = 1'b0;
	bit        rx_throttle = 1'b0;
	int        rx_hold = 0;

	// limit 0 behaves as 1, anything past the list depth as the depth
	function automatic int effective_limit();
		if (voice_limit == 0)
			return 1;
		if (voice_limit > VOICES)
			return VOICES;
		return voice_limit;
	endfunction

	function automatic int find_sounding(logic [NOTE_W-1:0] nt);
		for (int i = 0; i < sounding_cnt; i++)
			if (sounding[i] == nt)
				return i;
		return -1;
	endfunction

	// update the list model for one accepted key event, queue its results
	task automatic allocate_voices(input logic kind, input logic [NOTE_W-1:0] nt);
		int pos;
		if (kind == REQ_ON) begin
			// full list: oldest note is stolen first, even for a duplicate
			if (sounding_cnt >= effective_limit() && sounding_cnt > 0) begin
				sounding_cnt = sounding_cnt - 1;
				pending_results.push_back('{voice_note: sounding[sounding_cnt], gate_on: 1'b0,
					stolen: 1'b1, active_count: sounding_cnt, last_result: 1'b0});
			end
			if (find_sounding(nt) < 0 && sounding_cnt < VOICES) begin
				for (int i = sounding_cnt; i > 0; i--)
					sounding[i] = sounding[i-1];
				sounding[0] = nt;
				sounding_cnt = sounding_cnt + 1;
			end
			pending_results.push_back('{voice_note: nt, gate_on: 1'b1, stolen: 1'b0,
				active_count: sounding_cnt, last_result: 1'b1});
		end else begin
			// absent note: list untouched, note-off still reported
			pos = find_sounding(nt);
			if (pos >= 0) begin
				for (int i = pos; i + 1 < sounding_cnt; i++)
					sounding[i] = sounding[i+1];
				sounding_cnt = sounding_cnt - 1;
			end
			pending_results.push_back('{voice_note: nt, gate_on: 1'b0, stolen: 1'b0,
				active_count: sounding_cnt, last_result: 1'b1});
		end
	endtask

	// mostly back-to-back or short, now and then a long pause
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Sender: valid stays high across back-to-back items (one NBA per step)
	// ------------------------------------------------------------------
	task automatic send_key(input logic kind, input logic [NOTE_W-1:0] nt);
		int gap;
		gap = tx_throttle ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{req_type: kind, note: nt};
		do
			@(posedge clk);
		while (!in_ready);
		allocate_voices(kind, nt);
	endtask

	// drop valid and hold off until every predicted item has been seen
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_voice_limit(input logic [LIMIT_W-1:0] lim);
		wait_results_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		voice_limit = lim;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls on out_ready
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
			rx_hold = idle_len();
			if (rx_hold > 0)
				rx_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// result monitor: every handshake is matched against the oldest prediction
	always @(posedge clk) begin
		vaos_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual note %0d gate %0d",
					$time, out_item.voice_note, out_item.gate_on);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("voice_note", want.voice_note, out_item.voice_note);
				compare_field("gate_on", want.gate_on, out_item.gate_on);
				compare_field("stolen", want.stolen, out_item.stolen);
				compare_field("active_count", want.active_count, out_item.active_count);
				compare_field("last_result", want.last_result, out_item.last_result);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset limit of 8: fill, steal the oldest, then a duplicate that steals itself
	task automatic test_fill_and_steal();
		logic [NOTE_W-1:0] fill_notes[8] = '{7'd0, 7'd127, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10};
		foreach (fill_notes[i])
			send_key(REQ_ON, fill_notes[i]);
		send_key(REQ_ON, 7'd42);
		// oldest is now 127: stolen and put back at the front
		send_key(REQ_ON, 7'd127);
	endtask

	// limit dropped under the occupancy: one steal per note-on only
	task automatic test_lowered_limit();
		set_voice_limit(4'd2);
		send_key(REQ_ON, 7'd99);
		send_key(REQ_OFF, 7'd99);
		send_key(REQ_OFF, 7'd100);
		send_key(REQ_OFF, 7'd127);
	endtask

	// limit 0 acts as 1, 15 acts as the list depth
	task automatic test_limit_extremes();
		set_voice_limit(4'd0);
		send_key(REQ_ON, 7'd3);
		send_key(REQ_ON, 7'd3);
		set_voice_limit(4'd15);
		send_key(REQ_ON, 7'd64);
		send_key(REQ_OFF, 7'd0);
		send_key(REQ_OFF, 7'd3);
	endtask

	// key traffic on a narrow band of notes so hits, duplicates and steals are common
	task automatic test_random_traffic(input logic [LIMIT_W-1:0] lim, input int n_keys,
			input bit tx_idle, input bit rx_idle);
		logic              kind;
		logic [NOTE_W-1:0] nt;
		set_voice_limit(lim);
		tx_throttle = tx_idle;
		rx_throttle = rx_idle;
		repeat (n_keys) begin
			kind = ($urandom_range(0, 99) < 55) ? REQ_ON : REQ_OFF;
			if (kind == REQ_OFF && sounding_cnt > 0 && $urandom_range(0, 99) < 70)
				nt = sounding[$urandom_range(0, sounding_cnt - 1)];
			else if ($urandom_range(0, 99) < 65)
				nt = NOTE_W'(60 + $urandom_range(0, 9));
			else
				nt = NOTE_W'($urandom_range(0, 127));
			send_key(kind, nt);
		end
	endtask

	initial begin
		logic [LIMIT_W-1:0] phase_limits[6];
		phase_limits = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd8, LIMIT_W'($urandom_range(0, 15))};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_throttle = 1'b1;
		rx_throttle = 1'b1;
		test_fill_and_steal();
		test_lowered_limit();
		test_limit_extremes();

		// idling on both sides, receiver only, sender only, in turn
		for (int p = 0; p < 6; p++)
			test_random_traffic(phase_limits[p], 90, (p % 3) != 1, (p % 3) != 2);

		wait_results_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
